>>> rtl/b62d_pkg.sv
// ----------------------------------------------------------------------------
// b62d_pkg
// Types, status codes and the character map shared by the base-62 decoder.
// ----------------------------------------------------------------------------
package b62d_pkg;

  localparam int NUM_DIGITS = 22;
  localparam int COUNT_W    = 5;
  localparam int DIGIT_W    = 6;
  localparam int VALUE_W    = 128;
  localparam int HALF_W     = 64;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [COUNT_W-1:0] COUNT_END = COUNT_W'(NUM_DIGITS);

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LEN     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADCHAR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVF     = 2'd3;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               bad;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic item_t map_char(input logic [7:0] ch, input logic last);
    item_t      it;
    logic [7:0] d;
    d       = 8'd0;
    it.bad  = 1'b0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d = ch - 8'h30;
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      d = ch - 8'd87;
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      d = ch - 8'd29;
    end else begin
      it.bad = 1'b1;
    end
    it.digit = d[DIGIT_W-1:0];
    it.last  = last;
    return it;
  endfunction

endpackage

>>> rtl/b62d_in_reg.sv
// ----------------------------------------------------------------------------
// b62d_in_reg
// Input register: maps each accepted character to its digit and holds it.
// ----------------------------------------------------------------------------
module b62d_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    character,
  input  logic          last_char,
  input  logic          load,
  input  logic          consume,
  output logic          valid,
  output b62d_pkg::item_t item
);
  import b62d_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= map_char(character, last_char);
    end
  end

endmodule

>>> rtl/b62d_accum.sv
// ----------------------------------------------------------------------------
// b62d_accum
// Accumulator state: acc*62+digit over 128 bits, digit count, first error.
// ----------------------------------------------------------------------------
module b62d_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              consume,
  input  b62d_pkg::item_t   item,
  output b62d_pkg::result_t result
);
  import b62d_pkg::*;

  logic [VALUE_W-1:0]   acc;
  logic [VALUE_W-1:0]   acc_next;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [STATUS_W-1:0]  first_error;
  logic [STATUS_W-1:0]  first_error_next;
  logic [VALUE_W+5:0]   prod;
  logic                 ovf;

  always_comb begin
    prod = {acc, 6'b0} - {5'b0, acc, 1'b0} + {{VALUE_W{1'b0}}, item.digit};
    ovf  = |prod[VALUE_W+5:VALUE_W];

    count_next       = (count < COUNT_MAX) ? count + 5'd1 : count;
    acc_next         = acc;
    first_error_next = first_error;
    if (first_error == ST_OK) begin
      if (item.bad) begin
        first_error_next = ST_BADCHAR;
      end else if (ovf) begin
        first_error_next = ST_OVF;
      end else begin
        acc_next = prod[VALUE_W-1:0];
      end
    end

    result.status = (count_next != COUNT_END) ? ST_LEN : first_error_next;
    result.value  = (result.status == ST_OK) ? acc_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      count       <= '0;
      first_error <= ST_OK;
    end else if (consume) begin
      if (item.last) begin
        acc         <= '0;
        count       <= '0;
        first_error <= ST_OK;
      end else begin
        acc         <= acc_next;
        count       <= count_next;
        first_error <= first_error_next;
      end
    end
  end

endmodule

>>> rtl/base62_string_to_128bit_decoder.sv
// ----------------------------------------------------------------------------
// base62_string_to_128bit_decoder
// Decodes a base-62 identifier, one character per request, into 128 bits.
// ----------------------------------------------------------------------------
// One character is taken every cycle, save during the stall named below. A
// character is held in the input register and is folded into the 128-bit
// accumulator as it leaves; the character flagged last_char writes its result
// into the output register at that same edge, so a result passes the input
// register and then the output register. The only stall is a last character
// held while the previous result waits.
// Status: 0 ok, 1 wrong length (count other than 22, takes precedence),
// 2 invalid character, 3 overflow; the value is zero unless status is ok.
module base62_string_to_128bit_decoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     character,
  input  logic                           last_char,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [b62d_pkg::HALF_W-1:0]    value_high,
  output logic [b62d_pkg::HALF_W-1:0]    value_low,
  output logic [b62d_pkg::STATUS_W-1:0]  status
);
  import b62d_pkg::*;

  logic    item_valid;
  item_t   item;
  result_t result;
  logic    consume;
  logic    emit;

  assign consume  = item_valid && (!item.last || !out_valid || out_ready);
  assign emit     = consume && item.last;
  assign in_ready = !item_valid || consume;

  b62d_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .character (character),
    .last_char (last_char),
    .load      (in_valid && in_ready),
    .consume   (consume),
    .valid     (item_valid),
    .item      (item)
  );

  b62d_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .consume (consume),
    .item    (item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_high <= result.value[VALUE_W-1:HALF_W];
      value_low  <= result.value[HALF_W-1:0];
      status     <= result.status;
    end
  end

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value_high == '0 && value_low == '0)
    else $error("non-zero value with error status");

  a_mid_never_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item.last |-> in_ready)
    else $error("stall on a character that is not last");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("result without a last character");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");

endmodule
